>>> rtl/pwmt_pkg.sv
// ----------------------------------------------------------------------------
// pwmt_pkg
// shared types and constants for the prescaled pwm timer
// ----------------------------------------------------------------------------
package pwmt_pkg;

  // field widths of the transfer payloads and registers
  localparam int REQ_W       = 3;
  localparam int CHAN_IDX_W  = 2;
  localparam int DUTY_W      = 17;
  localparam int PRESCALE_W  = 16;
  localparam int RELOAD_W    = 16;
  localparam int CHAN_EN_W   = 4;
  localparam int PWM_W       = 4;
  localparam int COUNT_OUT_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // duty arithmetic, unsigned q1.16
  localparam int FRAC_BITS = 16;
  localparam int PRODUCT_W = RELOAD_W + DUTY_W;
  localparam logic [DUTY_W-1:0] DUTY_ONE = 17'h10000;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK         = 3'd0,
    REQ_SET_DUTY     = 3'd1,
    REQ_START        = 3'd2,
    REQ_STOP         = 3'd3,
    REQ_CLEAR_FLAG   = 3'd4,
    REQ_FORCE_UPDATE = 3'd5
  } req_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PRESCALE = 3'd0,
    CFG_RELOAD   = 3'd1,
    CFG_CHAN_EN  = 3'd2,
    CFG_IRQ_EN   = 3'd3,
    CFG_MAIN_OE  = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic [CHAN_IDX_W-1:0] channel;
    logic [DUTY_W-1:0]     duty_fraction;
  } in_item_t;

  typedef struct packed {
    logic [PWM_W-1:0]       pwm_level;
    logic                   update_flag;
    logic                   irq;
    logic [COUNT_OUT_W-1:0] count_value;
    logic                   running;
  } out_item_t;

  // compare write request into the channel bank
  typedef struct packed {
    logic                  en;
    logic [CHAN_IDX_W-1:0] channel;
    logic [DUTY_W-1:0]     duty_fraction;
  } chan_wr_t;

  // output gating controls
  typedef struct packed {
    logic                 main_oe;
    logic [CHAN_EN_W-1:0] chan_en;
  } pwm_gate_t;

endpackage

>>> rtl/pwmt_if.sv
// ----------------------------------------------------------------------------
// pwmt_in_if / pwmt_out_if
// valid/ready channels carrying request and result items
// ----------------------------------------------------------------------------
interface pwmt_in_if import pwmt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pwmt_out_if import pwmt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/pwmt_chan_bank.sv
// ----------------------------------------------------------------------------
// pwmt_chan_bank
// per-channel compare registers, duty to compare scaling and pwm mode 1 levels
// ----------------------------------------------------------------------------
module pwmt_chan_bank import pwmt_pkg::*; #(
  parameter int CHANNELS    = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  chan_wr_t               wr,
  input  logic [RELOAD_W-1:0]    reload_eff,
  input  logic [COUNT_WIDTH-1:0] count_nxt,
  input  pwm_gate_t              gate,
  output logic [PWM_W-1:0]       level_nxt
);

  // compare never exceeds reload, so it fits the narrower of the two
  localparam int CMP_W = (COUNT_WIDTH < RELOAD_W) ? COUNT_WIDTH : RELOAD_W;

  logic [DUTY_W-1:0]    duty_sat;
  logic [PRODUCT_W-1:0] product;
  logic [CMP_W-1:0]     cmp_new;
  logic [CMP_W-1:0]     cmp_r   [CHANNELS];
  logic [CMP_W-1:0]     cmp_nxt [CHANNELS];

  // duty above one saturates
  assign duty_sat = (wr.duty_fraction > DUTY_ONE) ? DUTY_ONE : wr.duty_fraction;
  assign product  = PRODUCT_W'(reload_eff) * PRODUCT_W'(duty_sat);
  assign cmp_new  = product[FRAC_BITS +: CMP_W];

  // writes to a channel index without hardware match nothing
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      cmp_nxt[i] = cmp_r[i];
      if (wr.en && (wr.channel == CHAN_IDX_W'(i))) begin
        cmp_nxt[i] = cmp_new;
      end
    end
  end

  always_comb begin
    level_nxt = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      level_nxt[i] = gate.main_oe && gate.chan_en[i] &&
                     (count_nxt < COUNT_WIDTH'(cmp_nxt[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cmp_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        cmp_r[i] <= cmp_nxt[i];
      end
    end
  end

endmodule

>>> rtl/prescaled_pwm_timer.sv
// ----------------------------------------------------------------------------
// prescaled_pwm_timer
// up-counting timer with prescaler, autoreload and edge-aligned pwm channels
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake       payload
//  --------  ---  --------------  ---------------------------------------------
//  in_chan   in   valid/ready     req_type, channel, duty_fraction
//  out_chan  out  valid/ready     pwm_level, update_flag, irq, count_value,
//                                 running
//  cfg_*     in   write enable    cfg_index, cfg_wdata (no read-back)
//
//  one request per clock is sustained while out_chan is ready; a request waits
//  in the input register until the output register is free, executes there and
//  its result is loaded into the output register, which offers it on out_chan
//  reset is synchronous and active low; it clears counters, flags, compares
//  and the run bit, and loads reload with all ones
//  a stalled output holds its result while the input register still takes one
//  more request; after that in_chan.ready drops until out_chan moves
//
module prescaled_pwm_timer import pwmt_pkg::*; #(
  parameter int CHANNELS    = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  pwmt_in_if.sink                in_chan,
  pwmt_out_if.source             out_chan
);

  // low bits of reload and count that are visible at the given width
  localparam int LO_W = (COUNT_WIDTH < RELOAD_W) ? COUNT_WIDTH : RELOAD_W;

  // configuration registers
  logic [PRESCALE_W-1:0] prescale_r;
  logic [RELOAD_W-1:0]   reload_r;
  logic [CHAN_EN_W-1:0]  chan_en_r;
  logic                  irq_en_r;
  logic                  main_oe_r;

  // timer state
  logic [PRESCALE_W-1:0]  pcount_r, pcount_nxt;
  logic [COUNT_WIDTH-1:0] mcount_r, mcount_nxt;
  logic                   run_r, run_nxt;
  logic                   flag_r, flag_nxt;

  // pipeline registers
  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic                   exec;
  logic                   in_xfer;
  logic [RELOAD_W-1:0]    reload_eff;
  logic [COUNT_WIDTH-1:0] reload_cmp;
  logic [PWM_W-1:0]       level_nxt;
  logic [COUNT_OUT_W-1:0] count_out;
  chan_wr_t               chan_wr;
  pwm_gate_t              gate;

  // ---------------------------------------------------------------------------
  // handshake: the held request executes once the output register is free
  // ---------------------------------------------------------------------------
  assign exec           = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !in_valid_r || exec;
  assign in_xfer        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_item_r;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (exec) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // reload masked to the counter width
  // ---------------------------------------------------------------------------
  always_comb begin
    reload_eff = '0;
    reload_eff[LO_W-1:0] = reload_r[LO_W-1:0];
  end
  assign reload_cmp = COUNT_WIDTH'(reload_eff);

  // ---------------------------------------------------------------------------
  // request execution: one state update per executed request
  // ---------------------------------------------------------------------------
  always_comb begin
    pcount_nxt = pcount_r;
    mcount_nxt = mcount_r;
    run_nxt    = run_r;
    flag_nxt   = flag_r;
    chan_wr    = '{en: 1'b0, channel: in_item_r.channel,
                   duty_fraction: in_item_r.duty_fraction};
    if (exec) begin
      unique case (req_t'(in_item_r.req_type))
        REQ_TICK: begin
          // a stopped timer ignores ticks
          if (run_r) begin
            // limit test uses >= so a lowered register still wraps
            if (pcount_r >= prescale_r) begin
              pcount_nxt = '0;
              if (mcount_r >= reload_cmp) begin
                mcount_nxt = '0;
                flag_nxt   = 1'b1;
              end else begin
                mcount_nxt = mcount_r + COUNT_WIDTH'(1);
              end
            end else begin
              pcount_nxt = pcount_r + PRESCALE_W'(1);
            end
          end
        end
        REQ_SET_DUTY: begin
          chan_wr.en = 1'b1;
        end
        REQ_START: begin
          run_nxt = 1'b1;
        end
        REQ_STOP: begin
          run_nxt = 1'b0;
        end
        REQ_CLEAR_FLAG: begin
          flag_nxt = 1'b0;
        end
        REQ_FORCE_UPDATE: begin
          // flag is left as is
          pcount_nxt = '0;
          mcount_nxt = '0;
        end
        default: begin
          // unused codes only report the current state
        end
      endcase
    end
  end

  assign gate = '{main_oe: main_oe_r, chan_en: chan_en_r};

  pwmt_chan_bank #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_chan_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (chan_wr),
    .reload_eff (reload_eff),
    .count_nxt  (mcount_nxt),
    .gate       (gate),
    .level_nxt  (level_nxt)
  );

  // ---------------------------------------------------------------------------
  // result formatting, reported after the update
  // ---------------------------------------------------------------------------
  always_comb begin
    count_out = '0;
    count_out[LO_W-1:0] = mcount_nxt[LO_W-1:0];
  end

  always_comb begin
    out_item_nxt.pwm_level   = level_nxt;
    out_item_nxt.update_flag = flag_nxt;
    out_item_nxt.irq         = flag_nxt && irq_en_r;
    out_item_nxt.count_value = count_out;
    out_item_nxt.running     = run_nxt;
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= '0;
      reload_r   <= '1;
      chan_en_r  <= '0;
      irq_en_r   <= 1'b0;
      main_oe_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PRESCALE: prescale_r <= cfg_wdata[PRESCALE_W-1:0];
        CFG_RELOAD:   reload_r   <= cfg_wdata[RELOAD_W-1:0];
        CFG_CHAN_EN:  chan_en_r  <= cfg_wdata[CHAN_EN_W-1:0];
        CFG_IRQ_EN:   irq_en_r   <= cfg_wdata[0];
        CFG_MAIN_OE:  main_oe_r  <= cfg_wdata[0];
        default: begin
          // index beyond the register list, write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r    <= '0;
      mcount_r    <= '0;
      run_r       <= 1'b0;
      flag_r      <= 1'b0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pcount_r    <= pcount_nxt;
      mcount_r    <= mcount_nxt;
      run_r       <= run_nxt;
      flag_r      <= flag_nxt;
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_chan.data;
    end
    if (exec) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

>>> verif/tb_prescaled_pwm_timer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_prescaled_pwm_timer
// self-checking bench for the prescaled pwm timer: a shadow of the counters,
// flags and compare registers predicts every status result, directed requests
// hit the corner cases, then random phases run the timer under varied settings
// with random idling, no-idle stretches and a long output hold-off
// ----------------------------------------------------------------------------
module tb_prescaled_pwm_timer import pwmt_pkg::*; ();

  localparam int NUM_PHASES       = 8;
  localparam int ITEMS_PER_PHASE  = 160;
  localparam int MAX_GAP          = 8;
  localparam int LONG_HOLD        = 48;
  localparam int DRAIN_CYCLES     = 4;
  localparam int IDLE_LIMIT       = 2000;

  // request codes the block treats as no-ops, and a register index past the list
  localparam logic [REQ_W-1:0]       REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0]       REQ_SPARE_HI = 3'd7;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED   = 3'd7;

  // --------------------------------------------------------------------------
  // shadow of the timer state; predicts the status after each request
  // --------------------------------------------------------------------------
  class timer_shadow;
    logic [PRESCALE_W-1:0]  prescale_val;
    logic [RELOAD_W-1:0]    reload_val;
    logic [CHAN_EN_W-1:0]   chan_en;
    logic                   irq_en;
    logic                   main_oe;
    logic [PRESCALE_W-1:0]  presc_cnt;
    logic [COUNT_OUT_W-1:0] main_cnt;
    logic [RELOAD_W-1:0]    compare [PWM_W];
    logic                   run;
    logic                   flag;
    out_item_t              expected_status_q [$];
    int                     errors;
    int                     checked;
    int                     wraps;

    function new();
      prescale_val = '0;
      reload_val   = '1;
      chan_en      = '0;
      irq_en       = 1'b0;
      main_oe      = 1'b0;
      presc_cnt    = '0;
      main_cnt     = '0;
      foreach (compare[i]) compare[i] = '0;
      run          = 1'b0;
      flag         = 1'b0;
      errors       = 0;
      checked      = 0;
      wraps        = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PRESCALE: prescale_val = data[PRESCALE_W-1:0];
        CFG_RELOAD:   reload_val   = data[RELOAD_W-1:0];
        CFG_CHAN_EN:  chan_en      = data[CHAN_EN_W-1:0];
        CFG_IRQ_EN:   irq_en       = data[0];
        CFG_MAIN_OE:  main_oe      = data[0];
        default: ;
      endcase
    endfunction

    // one tick of the prescaler and, on its wrap, one step of the main counter
    function void tick();
      if (!run) return;
      if (presc_cnt >= prescale_val) begin
        presc_cnt = '0;
        if (main_cnt >= reload_val) begin
          main_cnt = '0;
          flag     = 1'b1;
          wraps++;
        end else begin
          main_cnt = main_cnt + 1'b1;
        end
      end else begin
        presc_cnt = presc_cnt + 1'b1;
      end
    endfunction

    function void predict_status(in_item_t req);
      logic [DUTY_W-1:0]    duty;
      logic [PRODUCT_W-1:0] product;
      out_item_t            status;
      case (req.req_type)
        REQ_TICK: tick();
        REQ_SET_DUTY: begin
          duty = (req.duty_fraction > DUTY_ONE) ? DUTY_ONE : req.duty_fraction;
          product = reload_val * duty;
          compare[req.channel] = product[FRAC_BITS +: RELOAD_W];
        end
        REQ_START:        run = 1'b1;
        REQ_STOP:         run = 1'b0;
        REQ_CLEAR_FLAG:   flag = 1'b0;
        REQ_FORCE_UPDATE: begin
          presc_cnt = '0;
          main_cnt  = '0;
        end
        default: ;
      endcase
      status.pwm_level = '0;
      for (int i = 0; i < PWM_W; i++)
        status.pwm_level[i] = main_oe && chan_en[i] && (main_cnt < compare[i]);
      status.update_flag = flag;
      status.irq         = flag & irq_en;
      status.count_value = main_cnt;
      status.running     = run;
      expected_status_q.push_back(status);
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (expected_status_q.size() == 0) begin
        $error("status result with nothing expected: %p", got);
        errors++;
        return;
      end
      want = expected_status_q.pop_front();
      checked++;
      if (got.pwm_level !== want.pwm_level) begin
        $error("pwm_level expected %h got %h", want.pwm_level, got.pwm_level);
        errors++;
      end
      if (got.update_flag !== want.update_flag) begin
        $error("update_flag expected %b got %b", want.update_flag, got.update_flag);
        errors++;
      end
      if (got.irq !== want.irq) begin
        $error("irq expected %b got %b", want.irq, got.irq);
        errors++;
      end
      if (got.count_value !== want.count_value) begin
        $error("count_value expected %0d got %0d", want.count_value, got.count_value);
        errors++;
      end
      if (got.running !== want.running) begin
        $error("running expected %b got %b", want.running, got.running);
        errors++;
      end
    endfunction

    function int pending();
      return expected_status_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, dut
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  pwmt_in_if  in_chan ();
  pwmt_out_if out_chan ();

  prescaled_pwm_timer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  timer_shadow timer = new();

  // knobs for the request driver and the status receiver
  bit sender_busy;     // no gaps between requests
  bit receiver_busy;   // ready held high
  bit hold_request;    // receiver makes one long hold-off of LONG_HOLD
  int requests_sent;
  int long_holds;
  int settings_used;

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // offer one request after a random gap, none while sender_busy is set; returns right after its transfer
  task automatic send_request(in_item_t req);
    int gap;
    gap = sender_busy ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.data  <= req;
    do @(posedge clk); while (!in_chan.ready);
    timer.predict_status(req);
    requests_sent++;
  endtask

  // register write; the shadow takes the value at the same edge as the block
  task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    timer.write_reg(idx, data);
  endtask

  // all five registers plus a write past the list; noise above the chan_en, irq_en and main_oe fields
  task automatic program_timer(logic [PRESCALE_W-1:0] presc, logic [RELOAD_W-1:0] rld,
                               logic [CHAN_EN_W-1:0] chans, logic irq_on, logic oe_on);
    write_cfg(CFG_PRESCALE, presc);
    write_cfg(CFG_RELOAD, rld);
    write_cfg(CFG_CHAN_EN, {12'($urandom), chans});
    write_cfg(CFG_IRQ_EN, {15'($urandom), irq_on});
    write_cfg(CFG_MAIN_OE, {15'($urandom), oe_on});
    write_cfg(CFG_UNUSED, 16'($urandom));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // stop offering and let every outstanding status come back
  task automatic drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (timer.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t make_request(logic [REQ_W-1:0] code, int chan, int duty);
    in_item_t req;
    req.req_type      = code;
    req.channel       = chan[CHAN_IDX_W-1:0];
    req.duty_fraction = duty[DUTY_W-1:0];
    return req;
  endfunction

  // mostly ticks with the timer running, so counters wrap often;
  // channel and duty carry random bits on every request
  function automatic in_item_t random_request();
    int       pick;
    int       duty;
    in_item_t req;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       duty = DUTY_ONE;
      1:       duty = 0;
      default: duty = $urandom_range(0, 17'h1FFFF);
    endcase
    req = make_request(REQ_TICK, $urandom_range(0, 3), duty);
    if (pick >= 97)      req.req_type = REQ_SPARE_HI;
    else if (pick >= 94) req.req_type = REQ_SPARE_LO;
    else if (pick >= 91) req.req_type = REQ_FORCE_UPDATE;
    else if (pick >= 85) req.req_type = REQ_CLEAR_FLAG;
    else if (pick >= 82) req.req_type = REQ_STOP;
    else if (pick >= 74) req.req_type = REQ_START;
    else if (pick >= 62) req.req_type = REQ_SET_DUTY;
    return req;
  endfunction

  // settings per phase: zero reload, all-max prescale and reload, then lowered limits so
  // the counters sit above them, then small random values that wrap quickly
  task automatic apply_phase_settings(int phase);
    case (phase)
      0: program_timer(16'd0, 16'd0, 4'hF, 1'b1, 1'b1);
      1: program_timer(16'hFFFF, 16'hFFFF, 4'h0, 1'b0, 1'b1);
      2: program_timer(16'd0, 16'hFFFF, 4'hF, 1'b1, 1'b1);
      3: program_timer(16'd0, 16'd2, 4'hF, 1'b1, 1'b0);
      default: program_timer(PRESCALE_W'($urandom_range(0, 3)),
                             RELOAD_W'($urandom_range(1, 48)),
                             CHAN_EN_W'($urandom_range(0, 15)),
                             1'($urandom_range(0, 1)),
                             $urandom_range(0, 3) != 0);
    endcase
  endtask

  // --------------------------------------------------------------------------
  // status receiver: random stalls, occasionally one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        stall        = LONG_HOLD;
        hold_request = 1'b0;
        long_holds++;
      end else begin
        stall = receiver_busy ? 0 : $urandom_range(0, MAX_GAP);
      end
      repeat (stall) begin
        @(negedge clk);
        out_chan.ready <= 1'b0;
      end
      @(negedge clk);
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      timer.check_status(out_chan.data);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: ends the run after a long stretch with no transfer on either side
  // --------------------------------------------------------------------------
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $error("no transfer for %0d cycles, %0d statuses outstanding",
           IDLE_LIMIT, timer.pending());
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    sender_busy   = 1'b0;
    receiver_busy = 1'b0;
    hold_request  = 1'b0;
    requests_sent = 0;
    long_holds    = 0;
    settings_used = 0;
    rst_n         = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part: prescale 1, reload 5, every gate open
    // compares come out as 0, 5, 5 (duty above one saturates) and 2
    program_timer(16'd1, 16'd5, 4'hF, 1'b1, 1'b1);
    send_request(make_request(REQ_SET_DUTY, 0, 0));
    send_request(make_request(REQ_SET_DUTY, 1, DUTY_ONE));
    send_request(make_request(REQ_SET_DUTY, 2, 17'h1FFFF));
    send_request(make_request(REQ_SET_DUTY, 3, 17'h08000));
    send_request(make_request(REQ_TICK, 0, 0));           // tick while stopped
    send_request(make_request(REQ_START, 0, 0));
    send_request(make_request(REQ_START, 3, 17'h1FFFF));  // start while running
    repeat (13) send_request(make_request(REQ_TICK, 0, 0)); // runs through a wrap
    send_request(make_request(REQ_SPARE_LO, 2, 17'h15555));
    send_request(make_request(REQ_SPARE_HI, 1, 17'h0AAAA));
    send_request(make_request(REQ_FORCE_UPDATE, 0, 0));
    send_request(make_request(REQ_CLEAR_FLAG, 0, 0));
    send_request(make_request(REQ_STOP, 0, 0));
    send_request(make_request(REQ_TICK, 0, 0));
    drain();

    // random phases, each under fresh settings; the counters carry over
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      apply_phase_settings(phase);
      sender_busy   = (phase == 2) || (phase == 4) || (phase == 6);
      receiver_busy = (phase == 2) || (phase == 5);
      // sender keeps pushing while the receiver holds off: fills the pipe
      hold_request  = (phase == 4) || (phase == 6);
      send_request(make_request(REQ_START, 0, 0));
      repeat (ITEMS_PER_PHASE) send_request(random_request());
      drain();
    end

    if (timer.pending() != 0) begin
      $error("%0d expected statuses never arrived", timer.pending());
      timer.errors++;
    end
    $display("summary: %0d requests under %0d register settings, %0d statuses compared",
             requests_sent, settings_used, timer.checked);
    $display("summary: %0d counter wraps, %0d long output hold-offs, %0d mismatches",
             timer.wraps, long_holds, timer.errors);
    if (timer.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
